### sv/fqs_pkg.sv
// Package for the searchable FIFO queue: sizes, request and status codes,
// state machine type, and the structs passed between the queue's modules.
// Depends on nothing; every other file imports it.
package fqs_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int IDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;
    localparam int POS_FIELD_W   = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_FIND = 2'd2
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_FIND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        t_status                  status_code;
        logic [DATA_W-1:0]        popped_value;
        logic [DATA_W-1:0]        head_value;
        logic                     is_empty;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic [COUNT_FIELD_W-1:0] even_count;
        logic                     found;
        logic [POS_FIELD_W-1:0]   found_position;
    } t_result;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (32'(idx) == QUEUE_DEPTH - 1) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [COUNT_FIELD_W-1:0] to_count_field(
        input logic [COUNT_W-1:0] c
    );
        logic [31:0] w;
        w = 32'(c);
        return w[COUNT_FIELD_W-1:0];
    endfunction

    function automatic logic [POS_FIELD_W-1:0] to_pos_field(input logic [IDX_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[POS_FIELD_W-1:0];
    endfunction

endpackage

### sv/fqs_req_if.sv
// Request channel of the searchable FIFO queue: valid, ready and the request item.
// Depends on fqs_pkg for field widths.
interface fqs_req_if;
    import fqs_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

### sv/fqs_rsp_if.sv
// Result channel of the searchable FIFO queue: valid, ready and the result item.
// Depends on fqs_pkg for field widths.
interface fqs_rsp_if;
    import fqs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status_code;
    logic signed [DATA_W-1:0]  popped_value;
    logic signed [DATA_W-1:0]  head_value;
    logic                      is_empty;
    logic [COUNT_FIELD_W-1:0]  entry_count;
    logic [COUNT_FIELD_W-1:0]  even_count;
    logic                      found;
    logic [POS_FIELD_W-1:0]    found_position;

    modport source (
        output valid, output status_code, output popped_value, output head_value,
        output is_empty, output entry_count, output even_count, output found,
        output found_position, input ready
    );
    modport sink (
        input valid, input status_code, input popped_value, input head_value,
        input is_empty, input entry_count, input even_count, input found,
        input found_position, output ready
    );
endinterface

### sv/fqs_store.sv
// Entry memory of the searchable FIFO queue: one write port, one read port
// with registered read data. Depends on fqs_pkg.
module fqs_store (
    input  logic                      i_clk,
    input  fqs_pkg::t_mem_wr          i_wr,
    input  fqs_pkg::t_mem_rd          i_rd,
    output logic [fqs_pkg::DATA_W-1:0] o_rd_data
);
    import fqs_pkg::*;

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/fqs_ctrl.sv
// Sequencer of the searchable FIFO queue: pointers, counts, head cache and the
// search walk over the entry memory. Depends on fqs_pkg and fqs_req_if.
module fqs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fqs_req_if.sink                    i_req,
    output fqs_pkg::t_mem_wr           o_mem_wr,
    output fqs_pkg::t_mem_rd           o_mem_rd,
    input  logic [fqs_pkg::DATA_W-1:0] i_rd_data,
    output fqs_pkg::t_result           o_result,
    output logic                       o_result_load,
    input  logic                       i_out_free
);
    import fqs_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_even, n_even;
    logic [DATA_W-1:0]  r_head_val, n_head_val;
    logic [DATA_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]   r_scan, n_scan;
    logic [IDX_W-1:0]   r_scan_addr, n_scan_addr;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_popped, n_popped;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_pos, n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_even  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_even  <= n_even;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_val  <= n_head_val;
        r_key       <= n_key;
        r_scan      <= n_scan;
        r_scan_addr <= n_scan_addr;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_found     <= n_found;
        r_pos       <= n_pos;
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_even        = r_even;
        n_head_val    = r_head_val;
        n_key         = r_key;
        n_scan        = r_scan;
        n_scan_addr   = r_scan_addr;
        n_status      = r_status;
        n_popped      = r_popped;
        n_found       = r_found;
        n_pos         = r_pos;
        i_req.ready   = 1'b0;
        o_mem_wr      = '0;
        o_mem_rd      = '0;
        o_result_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            if (r_count == COUNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_wr.en   = 1'b1;
                                o_mem_wr.addr = r_tail;
                                o_mem_wr.data = i_req.operand_value;
                                n_tail        = next_slot(r_tail);
                                n_count       = r_count + COUNT_W'(1);
                                if (!i_req.operand_value[0]) begin
                                    n_even = r_even + COUNT_W'(1);
                                end
                                if (r_count == '0) begin
                                    n_head_val = i_req.operand_value;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped = r_head_val;
                                n_head   = next_slot(r_head);
                                n_count  = r_count - COUNT_W'(1);
                                if (!r_head_val[0]) begin
                                    n_even = r_even - COUNT_W'(1);
                                end
                                if (r_count != COUNT_W'(1)) begin
                                    o_mem_rd.en   = 1'b1;
                                    o_mem_rd.addr = next_slot(r_head);
                                    n_state       = S_POP_RD;
                                end
                            end
                        end
                        REQ_FIND: begin
                            n_key = i_req.operand_value;
                            if (r_count != '0) begin
                                o_mem_rd.en   = 1'b1;
                                o_mem_rd.addr = r_head;
                                n_scan        = '0;
                                n_scan_addr   = r_head;
                                n_state       = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_head_val = i_rd_data;
                n_state    = S_DONE;
            end
            S_FIND: begin
                if (i_rd_data == r_key) begin
                    n_found = 1'b1;
                    n_pos   = r_scan;
                    n_state = S_DONE;
                end else if ((COUNT_W'(r_scan) + COUNT_W'(1)) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_rd.en   = 1'b1;
                    o_mem_rd.addr = next_slot(r_scan_addr);
                    n_scan_addr   = next_slot(r_scan_addr);
                    n_scan        = r_scan + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_result_load = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.status_code    = r_status;
        o_result.popped_value   = r_popped;
        o_result.head_value     = (r_count != '0) ? r_head_val : '0;
        o_result.is_empty       = (r_count == '0);
        o_result.entry_count    = to_count_field(r_count);
        o_result.even_count     = to_count_field(r_even);
        o_result.found          = r_found;
        o_result.found_position = to_pos_field(r_pos);
    end

endmodule

### sv/fqs_out_reg.sv
// Output register of the searchable FIFO queue: holds one finished result
// until the result channel takes it. Depends on fqs_pkg and fqs_rsp_if.
module fqs_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fqs_pkg::t_result i_result,
    input  logic             i_load,
    output logic             o_free,
    fqs_rsp_if.source        o_rsp
);
    import fqs_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_free               = !r_valid || o_rsp.ready;
    assign o_rsp.valid          = r_valid;
    assign o_rsp.status_code    = r_result.status_code;
    assign o_rsp.popped_value   = r_result.popped_value;
    assign o_rsp.head_value     = r_result.head_value;
    assign o_rsp.is_empty       = r_result.is_empty;
    assign o_rsp.entry_count    = r_result.entry_count;
    assign o_rsp.even_count     = r_result.even_count;
    assign o_rsp.found          = r_result.found;
    assign o_rsp.found_position = r_result.found_position;

endmodule

### sv/fifo_queue_with_search.sv
// Top level of the searchable FIFO queue: sequencer, entry memory and output
// register. Depends on fqs_pkg, fqs_req_if, fqs_rsp_if and the fqs_ modules.
//
//   Channel  Direction  Item
//   i_req    in         req_type, operand_value
//   o_rsp    out        status_code, popped_value, head_value, is_empty,
//                       entry_count, even_count, found, found_position
//
// One item is in work at a time. Push, a refused request and an unused request
// kind go from idle straight to the delivery step; a pop that leaves entries
// first passes a read step, since the new head is read from the entry memory.
// Find does one memory read per entry walked. Reset empties the queue at once.
// A waiting result stalls only the delivery step of the following item.
module fifo_queue_with_search (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fqs_req_if.sink   i_req,
    fqs_rsp_if.source o_rsp
);
    import fqs_pkg::*;

    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    logic [DATA_W-1:0] rd_data;
    t_result           result;
    logic              result_load;
    logic              out_free;

    fqs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_mem_wr      (mem_wr),
        .o_mem_rd      (mem_rd),
        .i_rd_data     (rd_data),
        .o_result      (result),
        .o_result_load (result_load),
        .i_out_free    (out_free)
    );

    fqs_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd      (mem_rd),
        .o_rd_data (rd_data)
    );

    fqs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_load   (result_load),
        .o_free   (out_free),
        .o_rsp    (o_rsp)
    );

    a_one_item_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("A request was accepted while another item was in work.");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.is_empty == (o_rsp.entry_count == '0)))
        else $error("The empty flag disagrees with the entry count.");

    a_even_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.even_count <= o_rsp.entry_count))
        else $error("The even count exceeds the entry count.");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |->
            (COUNT_FIELD_W'(o_rsp.found_position) < o_rsp.entry_count))
        else $error("A match was reported beyond the held entries.");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_load |-> out_free)
        else $error("A result was loaded over one not yet taken.");

endmodule

### dv/fifo_queue_with_search_tb.sv
// Self-checking testbench for the searchable FIFO queue: random push, pop and find traffic
// with idle bursts on both channels, checked against an in-bench mirror of the queue.
// Depends on fqs_pkg, fqs_req_if, fqs_rsp_if and fifo_queue_with_search.
module fifo_queue_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS     = 1400;
    localparam int CALM_TAIL        = 200;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES    = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int TIMEOUT_NS       = 5_000_000;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_stim_mode;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [DATA_W-1:0] value;
        bit                drain_first;
    } t_queue_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fqs_req_if req_if ();
    fqs_rsp_if rsp_if ();

    fifo_queue_with_search u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_queue_req        pending_reqs[$];
    logic [DATA_W-1:0] planned_contents[$];
    t_result           awaited_results[$];

    logic [DATA_W-1:0] mirror_entries[QUEUE_DEPTH];
    int unsigned       mirror_head;
    int unsigned       mirror_tail;
    int                mirror_held;
    int                mirror_even;

    int n_total         = 0;
    int n_accepted      = 0;
    int n_checked       = 0;
    int n_errors        = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int long_hold_left  = 0;
    bit long_hold_done  = 1'b0;
    int kind_seen[4]    = '{default: 0};
    int n_full          = 0;
    int n_empty         = 0;
    int n_hit           = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result predict_queue_step(input logic [REQ_W-1:0] kind,
                                                   input logic [DATA_W-1:0] value);
        t_result     r;
        int unsigned slot;
        int          k;
        r = '0;
        case (kind)
            REQ_PUSH: begin
                if (mirror_held >= QUEUE_DEPTH) begin
                    r.status_code = ST_FULL;
                end else begin
                    mirror_entries[mirror_tail] = value;
                    mirror_tail = (mirror_tail + 1) % QUEUE_DEPTH;
                    mirror_held++;
                    if (!value[0]) mirror_even++;
                end
            end
            REQ_POP: begin
                if (mirror_held == 0) begin
                    r.status_code = ST_EMPTY;
                end else begin
                    r.popped_value = mirror_entries[mirror_head];
                    mirror_head = (mirror_head + 1) % QUEUE_DEPTH;
                    mirror_held--;
                    if (!r.popped_value[0]) mirror_even--;
                end
            end
            REQ_FIND: begin
                slot = mirror_head;
                for (k = 0; k < mirror_held; k++) begin
                    if (mirror_entries[slot] == value) begin
                        r.found = 1'b1;
                        r.found_position = POS_FIELD_W'(k);
                        break;
                    end
                    slot = (slot + 1) % QUEUE_DEPTH;
                end
            end
            default: ;
        endcase
        r.head_value  = (mirror_held != 0) ? mirror_entries[mirror_head] : '0;
        r.is_empty    = (mirror_held == 0);
        r.entry_count = COUNT_FIELD_W'(mirror_held);
        r.even_count  = COUNT_FIELD_W'(mirror_even);
        return r;
    endfunction

    function automatic void queue_up(input logic [REQ_W-1:0] kind,
                                     input logic [DATA_W-1:0] value,
                                     input bit drain_first = 1'b0);
        t_queue_req item;
        item.kind        = kind;
        item.value       = value;
        item.drain_first = drain_first;
        pending_reqs.push_back(item);
        case (kind)
            REQ_PUSH: if (planned_contents.size() < QUEUE_DEPTH) planned_contents.push_back(value);
            REQ_POP:  if (planned_contents.size() != 0) void'(planned_contents.pop_front());
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 8, 9: return $urandom;
            4, 5, 6: return DATA_W'($signed($urandom_range(0, 7)) - 4);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_key();
        if (planned_contents.size() != 0 && $urandom_range(0, 9) < 6)
            return planned_contents[$urandom_range(0, planned_contents.size() - 1)];
        return random_word();
    endfunction

    function automatic void note_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("result %0d: %s expected %h got %h", n_checked, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        bit      fired;
        bit      idle_ok;
        int      done_so_far;
        t_result want;
        if (!i_rst_n) begin
            req_if.valid         <= 1'b0;
            req_if.req_type      <= '0;
            req_if.operand_value <= '0;
            gap_left             <= 0;
            n_accepted           <= 0;
            mirror_head = 0;
            mirror_tail = 0;
            mirror_held = 0;
            mirror_even = 0;
        end else begin
            fired       = req_if.valid && req_if.ready;
            done_so_far = n_accepted + int'(fired);
            idle_ok     = done_so_far < n_total - CALM_TAIL && ((done_so_far / 150) % 3) != 2;
            if (fired) begin
                want = predict_queue_step(req_if.req_type, req_if.operand_value);
                awaited_results.push_back(want);
                kind_seen[req_if.req_type]++;
                if (want.status_code == ST_FULL) n_full++;
                if (want.status_code == ST_EMPTY) n_empty++;
                if (want.found) n_hit++;
                n_accepted <= done_so_far;
            end
            if (req_if.valid && !fired) begin
                // The offered item stays on the channel until it is taken.
            end else if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && done_so_far != n_checked)) begin
                if (idle_ok && $urandom_range(0, 3) == 0) begin
                    gap_left     <= $urandom_range(0, 14);
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid         <= 1'b1;
                    req_if.req_type      <= pending_reqs[0].kind;
                    req_if.operand_value <= pending_reqs[0].value;
                    void'(pending_reqs.pop_front());
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && n_accepted >= LONG_HOLD_AT) begin
            long_hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        bit      idle_ok;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            n_checked    <= 0;
        end else begin
            idle_ok = n_checked < n_total - CALM_TAIL && ((n_checked / 130) % 3) != 1;
            if (rsp_if.valid && rsp_if.ready) begin
                n_checked <= n_checked + 1;
                if (awaited_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("result %0d: arrived with nothing outstanding", n_checked);
                end else begin
                    want = awaited_results.pop_front();
                    note_field("status_code", 32'(want.status_code), 32'(rsp_if.status_code));
                    note_field("popped_value", want.popped_value, rsp_if.popped_value);
                    note_field("head_value", want.head_value, rsp_if.head_value);
                    note_field("is_empty", 32'(want.is_empty), 32'(rsp_if.is_empty));
                    note_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
                    note_field("even_count", 32'(want.even_count), 32'(rsp_if.even_count));
                    note_field("found", 32'(want.found), 32'(rsp_if.found));
                    note_field("found_position", 32'(want.found_position),
                               32'(rsp_if.found_position));
                end
            end
            if (stall_left != 0) begin
                stall_left   <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end else if (long_hold_left != 0) begin
                rsp_if.ready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 4) == 0) begin
                stall_left   <= $urandom_range(0, 14);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("fifo_queue_with_search: mismatch");
        $finish;
    end

    initial begin
        t_stim_mode mode;
        int         seg_len;
        int         n_random;
        int         roll;
        int         push_lim;
        int         pop_lim;
        int         i;
        logic [REQ_W-1:0] kind;

        i_rst_n = 1'b0;

        queue_up(REQ_POP, 32'h0);
        queue_up(REQ_FIND, 32'h0);
        queue_up(REQ_UNUSED, 32'hdead_beef);
        queue_up(REQ_PUSH, 32'h8000_0000);
        queue_up(REQ_PUSH, 32'h7fff_ffff);
        queue_up(REQ_PUSH, 32'hffff_ffff);
        queue_up(REQ_PUSH, 32'hffff_fffe);
        queue_up(REQ_FIND, 32'hffff_ffff);
        queue_up(REQ_FIND, 32'h8000_0000);
        queue_up(REQ_FIND, 32'h0000_0005);
        queue_up(REQ_UNUSED, 32'h0);
        queue_up(REQ_POP, 32'h0);
        for (i = 0; i < 13; i++) queue_up(REQ_PUSH, DATA_W'(i * 7 - 40));
        queue_up(REQ_PUSH, 32'h5555_5555);
        queue_up(REQ_FIND, DATA_W'(44));

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            mode    = t_stim_mode'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 60);
            case (mode)
                MODE_FILL:  begin push_lim = 65; pop_lim = 75; end
                MODE_DRAIN: begin push_lim = 15; pop_lim = 80; end
                default:    begin push_lim = 40; pop_lim = 70; end
            endcase
            for (i = 0; i < seg_len && n_random < RANDOM_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_lim)     kind = REQ_PUSH;
                else if (roll < pop_lim) kind = REQ_POP;
                else if (roll < 97)      kind = REQ_FIND;
                else                     kind = REQ_UNUSED;
                queue_up(kind, (kind == REQ_FIND) ? random_key() : random_word(),
                         (n_random % 250) == 0);
                n_random++;
            end
        end
        n_total = pending_reqs.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_accepted == n_total);
        wait (n_checked == n_accepted);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d pushes (%0d refused as full), %0d pops (%0d on empty),",
                 n_total, kind_seen[REQ_PUSH], n_full, kind_seen[REQ_POP], n_empty);
        $display("%0d finds (%0d hits) and %0d unused request kinds, with stalls on both sides.",
                 kind_seen[REQ_FIND], n_hit, kind_seen[REQ_UNUSED]);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("fifo_queue_with_search: match");
        end else begin
            $display("fifo_queue_with_search: mismatch");
        end
        $finish;
    end

endmodule
